>>> hdl/clamped_range_map_smoother_unit_macros.svh
// Assertion macros shared by the checker of the range map smoother.
`ifndef CLAMPED_RANGE_MAP_SMOOTHER_UNIT_MACROS_SVH
`define CLAMPED_RANGE_MAP_SMOOTHER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CRMS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crms assertion failed");

// Next-cycle implication, disabled while reset is low.
`define CRMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crms assertion failed");

`endif

>>> hdl/crms_pkg.sv
// Shared types and constants of the clamped range map smoother.
`default_nettype none

package crms_pkg;

    localparam int VALUE_W    = 32;
    localparam int FRAC_W     = 16;
    localparam int MODE_W     = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIFF_W     = VALUE_W + 1;
    // Interpolation fraction is unsigned Q0.31, one quotient bit per divider step.
    localparam int QUO_W      = 31;
    localparam int DIV_CNT_W  = $clog2(QUO_W);

    typedef logic [MODE_W-1:0]     t_mode;
    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;

    localparam t_mode MODE_FIXED  = 2'd0;
    localparam t_mode MODE_RANDOM = 2'd1;
    localparam t_mode MODE_LINKED = 2'd2;
    localparam t_mode MODE_HOLD   = 2'd3;

    localparam t_cfg_addr CFG_MODE         = 3'd0;
    localparam t_cfg_addr CFG_INPUT_LOWER  = 3'd1;
    localparam t_cfg_addr CFG_INPUT_UPPER  = 3'd2;
    localparam t_cfg_addr CFG_OUTPUT_LOWER = 3'd3;
    localparam t_cfg_addr CFG_OUTPUT_UPPER = 3'd4;
    localparam t_cfg_addr CFG_SMOOTH_COEFF = 3'd5;

    typedef enum logic [1:0] {
        MUL_RAND,
        MUL_INTERP,
        MUL_SM_TARGET,
        MUL_SM_PREV
    } t_mul_sel;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     tgt_rand;
        logic     tgt_clamp;
        logic     tgt_interp;
        logic     div_init;
        logic     div_step;
        logic     acc_load;
        logic     res_smooth;
        logic     res_fixed;
        logic     res_hold;
        logic     commit;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  clamped;
        logic  out_free;
    } t_status;

endpackage

`default_nettype wire

>>> hdl/crms_ifs.sv
// Valid/ready channel interfaces for the input and result words.
`default_nettype none

interface crms_in_if;
    import crms_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] input_value;
    logic        [FRAC_W-1:0]  random_fraction;

    modport source (output valid, output input_value, output random_fraction, input ready);
    modport sink   (input valid, input input_value, input random_fraction, output ready);
endinterface

interface crms_out_if;
    import crms_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] output_value;

    modport source (output valid, output output_value, input ready);
    modport sink   (input valid, input output_value, output ready);
endinterface

`default_nettype wire

>>> hdl/clamped_range_map_smoother_unit.sv
// Clamped linear range map with one-pole smoothing, top level. Each input word yields
// exactly one output word in signed Q16.16. Mode 0 outputs output_lower and loads it
// into the smoothed state; mode 1 aims at output_lower plus random_fraction times the
// output span; mode 2 clamps input_value to the input breakpoints (either order) and
// interpolates linearly between the output breakpoints; mode 3 repeats the last output.
// Modes 1 and 2 blend the target with the previous output by the smoothing coefficient,
// saturated at one. One word is worked on at a time. In linked mode with the input
// strictly between the breakpoints a word passes through the restoring divider, which
// yields one of the 31 fraction bits per cycle; random, clamped linked, fixed and hold
// words do not use the divider.
// A finished word sits in the output register, so the next input word is accepted while
// it waits; its result is committed only once that register is free. Settings are
// written through the plain write port and must only change while the block is idle.
`default_nettype none

module clamped_range_map_smoother_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int COEFF_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    crms_in_if.sink                         i_in,
    crms_out_if.source                      o_out,
    input  logic                            i_cfg_wr_en,
    input  crms_pkg::t_cfg_addr             i_cfg_addr,
    input  logic [crms_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import crms_pkg::*;

    // Command and status buses between the sequencer and the datapath.
    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    // The sequencer walks decode, divide, target and smoothing steps; it only
    // raises ready while idle, so one word is in flight besides the output word.
    crms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath holds the settings, the divider, one shared signed multiplier
    // with a registered product, and the smoothed state that drives the output.
    crms_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .COEFF_BITS (COEFF_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_input_value     (i_in.input_value),
        .i_random_fraction (i_in.random_fraction),
        .o_out_valid       (o_out.valid),
        .i_out_ready       (o_out.ready),
        .o_output_value    (o_out.output_value)
    );

    assign i_in.ready = in_ready;

endmodule

`default_nettype wire

>>> hdl/crms_ctrl.sv
// Sequencing state machine of the range map smoother.
`default_nettype none

module crms_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  crms_pkg::t_status i_status,
    output crms_pkg::t_cmd    o_cmd
);
    import crms_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RAND_ADD,
        S_DIV,
        S_INTERP_MUL,
        S_INTERP_ADD,
        S_SM_TARGET,
        S_SM_PREV,
        S_SM_SUM,
        S_DONE
    } t_state;

    t_state                 r_state, n_state;
    logic [DIV_CNT_W-1:0]   r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_RAND;
        o_in_ready    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_status.mode)
                    MODE_FIXED: begin
                        o_cmd.res_fixed = 1'b1;
                        n_state         = S_DONE;
                    end
                    MODE_RANDOM: begin
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.mul_sel = MUL_RAND;
                        n_state       = S_RAND_ADD;
                    end
                    MODE_LINKED: begin
                        if (i_status.clamped) begin
                            o_cmd.tgt_clamp = 1'b1;
                            n_state         = S_SM_TARGET;
                        end else begin
                            o_cmd.div_init = 1'b1;
                            n_cnt          = DIV_CNT_W'(QUO_W - 1);
                            n_state        = S_DIV;
                        end
                    end
                    default: begin
                        o_cmd.res_hold = 1'b1;
                        n_state        = S_DONE;
                    end
                endcase
            end
            S_RAND_ADD: begin
                o_cmd.tgt_rand = 1'b1;
                n_state        = S_SM_TARGET;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_INTERP_MUL;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_INTERP_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_INTERP;
                n_state       = S_INTERP_ADD;
            end
            S_INTERP_ADD: begin
                o_cmd.tgt_interp = 1'b1;
                n_state          = S_SM_TARGET;
            end
            S_SM_TARGET: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SM_TARGET;
                n_state       = S_SM_PREV;
            end
            S_SM_PREV: begin
                o_cmd.acc_load = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MUL_SM_PREV;
                n_state        = S_SM_SUM;
            end
            S_SM_SUM: begin
                o_cmd.res_smooth = 1'b1;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/crms_dp.sv
// Datapath of the range map smoother: settings, divider, shared multiplier, state.
`default_nettype none

module crms_dp #(
    parameter int DATA_WIDTH = 32,
    parameter int COEFF_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  crms_pkg::t_cmd                         i_cmd,
    output crms_pkg::t_status                      o_status,
    input  logic                                   i_cfg_wr_en,
    input  crms_pkg::t_cfg_addr                    i_cfg_addr,
    input  logic [crms_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic signed [crms_pkg::VALUE_W-1:0]    i_input_value,
    input  logic [crms_pkg::FRAC_W-1:0]            i_random_fraction,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [crms_pkg::VALUE_W-1:0]    o_output_value
);
    import crms_pkg::*;

    localparam int SAT_W = (DATA_WIDTH > VALUE_W) ? VALUE_W : DATA_WIDTH;
    localparam int ACC_W = VALUE_W + COEFF_BITS + 2;
    localparam int MUL_W = DIFF_W;
    localparam int PRD_W = 2 * MUL_W;

    localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (SAT_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
    localparam logic [COEFF_BITS:0]     C_ONE  = {1'b1, {COEFF_BITS{1'b0}}};

    function automatic logic signed [VALUE_W-1:0] sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        r = v;
        if (v > SAT_HI) begin
            r = SAT_HI;
        end else if (v < SAT_LO) begin
            r = SAT_LO;
        end
        return r[VALUE_W-1:0];
    endfunction

    // Settings
    t_mode                     r_mode;
    logic signed [VALUE_W-1:0] r_in_lo, r_in_hi, r_out_lo, r_out_hi;
    logic [COEFF_BITS:0]       r_coeff;

    // Item and working registers
    logic signed [VALUE_W-1:0] r_x;
    logic [FRAC_W-1:0]         r_rf;
    logic [VALUE_W-1:0]        r_rem;
    logic [QUO_W-1:0]          r_quo;
    logic signed [PRD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [VALUE_W-1:0] r_target;
    logic signed [VALUE_W-1:0] r_result;
    logic signed [VALUE_W-1:0] r_smoothed;
    logic                      r_out_valid;

    logic signed [DIFF_W-1:0]  out_diff, x_off, in_span;
    logic [VALUE_W-1:0]        num_abs, span_abs;
    logic                      x_le, x_ge, lo_lt_hi;
    logic signed [VALUE_W-1:0] clamp_target;
    logic [VALUE_W:0]          rem_sh;
    logic                      rem_ge;
    logic [VALUE_W:0]          rem_nxt;
    logic [COEFF_BITS:0]       c_sat, c_rest;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PRD_W-1:0]   rand_part, interp_part;
    logic signed [ACC_W-1:0]   acc_sum, acc_shr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_FIXED;
            r_in_lo  <= '0;
            r_in_hi  <= '0;
            r_out_lo <= '0;
            r_out_hi <= '0;
            r_coeff  <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_MODE:         r_mode   <= i_cfg_wdata[MODE_W-1:0];
                CFG_INPUT_LOWER:  r_in_lo  <= i_cfg_wdata[VALUE_W-1:0];
                CFG_INPUT_UPPER:  r_in_hi  <= i_cfg_wdata[VALUE_W-1:0];
                CFG_OUTPUT_LOWER: r_out_lo <= i_cfg_wdata[VALUE_W-1:0];
                CFG_OUTPUT_UPPER: r_out_hi <= i_cfg_wdata[VALUE_W-1:0];
                CFG_SMOOTH_COEFF: r_coeff  <= i_cfg_wdata[COEFF_BITS:0];
                default: ;
            endcase
        end
    end

    assign out_diff = $signed({r_out_hi[VALUE_W-1], r_out_hi})
                    - $signed({r_out_lo[VALUE_W-1], r_out_lo});
    assign x_off    = $signed({r_x[VALUE_W-1], r_x}) - $signed({r_in_lo[VALUE_W-1], r_in_lo});
    assign in_span  = $signed({r_in_hi[VALUE_W-1], r_in_hi})
                    - $signed({r_in_lo[VALUE_W-1], r_in_lo});

    // Differences of two 32-bit values have magnitudes below 2^32.
    always_comb begin
        logic signed [DIFF_W-1:0] na, sa;
        na       = (x_off < 0) ? -x_off : x_off;
        sa       = (in_span < 0) ? -in_span : in_span;
        num_abs  = na[VALUE_W-1:0];
        span_abs = sa[VALUE_W-1:0];
    end

    assign x_le     = (r_x <= r_in_lo) && (r_x <= r_in_hi);
    assign x_ge     = (r_x >= r_in_lo) && (r_x >= r_in_hi);
    assign lo_lt_hi = r_in_lo < r_in_hi;

    always_comb begin
        if (x_le) begin
            clamp_target = lo_lt_hi ? r_out_lo : r_out_hi;
        end else begin
            clamp_target = lo_lt_hi ? r_out_hi : r_out_lo;
        end
    end

    // Restoring divider step; the remainder stays below the span.
    assign rem_sh  = {r_rem, 1'b0};
    assign rem_ge  = rem_sh >= {1'b0, span_abs};
    assign rem_nxt = rem_ge ? (rem_sh - {1'b0, span_abs}) : rem_sh;

    assign c_sat  = (r_coeff > C_ONE) ? C_ONE : r_coeff;
    assign c_rest = C_ONE - c_sat;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_RAND: begin
                mul_a = out_diff;
                mul_b = $signed(MUL_W'(r_rf));
            end
            MUL_INTERP: begin
                mul_a = out_diff;
                mul_b = $signed(MUL_W'(r_quo));
            end
            MUL_SM_TARGET: begin
                mul_a = MUL_W'(r_target);
                mul_b = $signed(MUL_W'(c_rest));
            end
            default: begin
                mul_a = MUL_W'(r_smoothed);
                mul_b = $signed(MUL_W'(c_sat));
            end
        endcase
    end

    assign rand_part   = r_prod >>> FRAC_W;
    assign interp_part = r_prod >>> QUO_W;
    assign acc_sum     = r_acc + r_prod[ACC_W-1:0];
    assign acc_shr     = acc_sum >>> COEFF_BITS;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x  <= i_input_value;
            r_rf <= i_random_fraction;
        end
        if (i_cmd.div_init) begin
            r_rem <= num_abs;
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_nxt[VALUE_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], rem_ge};
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.acc_load) begin
            r_acc <= r_prod[ACC_W-1:0];
        end
        if (i_cmd.tgt_rand) begin
            r_target <= r_out_lo + rand_part[VALUE_W-1:0];
        end else if (i_cmd.tgt_interp) begin
            r_target <= r_out_lo + interp_part[VALUE_W-1:0];
        end else if (i_cmd.tgt_clamp) begin
            r_target <= clamp_target;
        end
        if (i_cmd.res_smooth) begin
            r_result <= sat(acc_shr);
        end else if (i_cmd.res_fixed) begin
            r_result <= sat(ACC_W'(r_out_lo));
        end else if (i_cmd.res_hold) begin
            r_result <= r_smoothed;
        end
    end

    // The smoothed state doubles as the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smoothed  <= '0;
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_smoothed  <= r_result;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_output_value    = r_smoothed;
    assign o_status.mode     = r_mode;
    assign o_status.clamped  = x_le || x_ge;
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

>>> hdl/crms_checker.sv
// Port-level checker of the range map smoother and its bind.
`default_nettype none

`include "clamped_range_map_smoother_unit_macros.svh"

module crms_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [crms_pkg::VALUE_W-1:0] i_output_value
);
    import crms_pkg::*;

    // Words accepted whose result has not yet been taken.
    logic [1:0] r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, i_in_valid && i_in_ready}
                             - {1'b0, i_out_valid && i_out_ready};
        end
    end

    `CRMS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_output_value))
    `CRMS_ASSERT_IMPL(a_no_orphan, i_clk, i_rst_n, i_out_valid, r_pend != 2'd0)
    `CRMS_ASSERT_IMPL(a_one_in_work, i_clk, i_rst_n, r_pend == 2'd2, !i_in_ready)

endmodule

bind clamped_range_map_smoother_unit crms_checker u_crms_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_output_value (o_out.output_value)
);

`default_nettype wire
